### rtl/core/eva_pkg.sv
package eva_pkg;

   localparam int VALUE_BITS_DEF    = 24;
   localparam int FRACTION_BITS_DEF = 16;
   localparam int DURATION_BITS     = 16;
   localparam int ELAPSED_BITS      = 16;
   localparam int MODE_BITS         = 3;
   localparam int OVERSHOOT_BITS    = 16;
   localparam int OVERSHOOT_FRAC    = 12;
   localparam int CSR_DATA_BITS     = 16;
   localparam int CSR_INDEX_BITS    = 1;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_EASING_MODE = 1'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_OVERSHOOT   = 1'd1;

   localparam logic [MODE_BITS-1:0] MODE_LINEAR = 3'd0;
   localparam logic [MODE_BITS-1:0] MODE_IN     = 3'd1;
   localparam logic [MODE_BITS-1:0] MODE_OUT    = 3'd2;
   localparam logic [MODE_BITS-1:0] MODE_IN_OUT = 3'd3;
   localparam logic [MODE_BITS-1:0] MODE_OUT_IN = 3'd4;

   localparam logic FUNC_TICK     = 1'b0;
   localparam logic FUNC_RETARGET = 1'b1;

   typedef struct packed {
      logic load;
      logic div_start;
      logic div_step;
      logic prog_update;
      logic mul_step;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic div_done;
      logic mul_done;
      logic retarget;
   } status_type;

endpackage

### rtl/core/eva_if.sv
interface eva_req_if #(
   parameter int VALUE_BITS = eva_pkg::VALUE_BITS_DEF
);
   logic                            valid;
   logic                            ready;
   logic                            func;
   logic [eva_pkg::ELAPSED_BITS-1:0]  elapsed;
   logic signed [VALUE_BITS-1:0]    new_target;
   logic [eva_pkg::DURATION_BITS-1:0] new_duration;
   modport source (output valid, func, elapsed, new_target, new_duration, input ready);
   modport sink   (input valid, func, elapsed, new_target, new_duration, output ready);
endinterface

interface eva_rsp_if #(
   parameter int VALUE_BITS = eva_pkg::VALUE_BITS_DEF
);
   logic                         valid;
   logic                         ready;
   logic signed [VALUE_BITS-1:0] value;
   logic                         done_res;
   modport source (output valid, value, done_res, input ready);
   modport sink   (input valid, value, done_res, output ready);
endinterface

### rtl/core/eased_value_animator.sv
// Eased value animator.
// Input channel req carries func (tick or retarget), elapsed, new_target
// and new_duration; each accepted item yields exactly one item on rsp with
// the current value and done_res.
// The csr port writes easing_mode (index 0) and overshoot (index 1); the user
// must write only while the block is idle, which the block does not enforce.
// A write takes effect at the next clock edge. A retarget item goes from the
// divide state straight to the output state without dividing. A tick item runs
// a 32-step restoring divider for elapsed/duration (skipped for a zero
// duration), one progress update, five steps (four through one shared
// multiplier, one add), and a final write of the value. A new item is
// accepted only after the result has transferred.
// One item is in flight at a time; req_ready is high only while idle.
// When the receiver stalls, the result holds on rsp until taken and no new
// item is accepted.
// Synchronous reset clears value, start, target, duration and progress to
// zero, sets easing_mode to ease-in and overshoot to zero.
module eased_value_animator #(
   parameter int VALUE_BITS    = eva_pkg::VALUE_BITS_DEF,
   parameter int FRACTION_BITS = eva_pkg::FRACTION_BITS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   eva_req_if.sink                               req,
   eva_rsp_if.source                             rsp,
   input  logic                                  csr_write_enable,
   input  logic [eva_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [eva_pkg::CSR_DATA_BITS-1:0]     csr_write_data
);
   import eva_pkg::*;

   logic [MODE_BITS-1:0]      mode_ff;
   logic [OVERSHOOT_BITS-1:0] overshoot_ff;
   cmd_type                   cmd;
   status_type                status;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_IN;
         overshoot_ff <= '0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_EASING_MODE: mode_ff      <= csr_write_data[MODE_BITS-1:0];
            CSR_OVERSHOOT:   overshoot_ff <= csr_write_data[OVERSHOOT_BITS-1:0];
            default: ;
         endcase
      end
   end

   eva_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .rsp_valid (rsp.valid),
      .rsp_ready (rsp.ready),
      .status    (status),
      .cmd       (cmd)
   );

   eva_dp #(
      .VALUE_BITS    (VALUE_BITS),
      .FRACTION_BITS (FRACTION_BITS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_func         (req.func),
      .req_elapsed      (req.elapsed),
      .req_new_target   (req.new_target),
      .req_new_duration (req.new_duration),
      .easing_mode      (mode_ff),
      .overshoot        (overshoot_ff),
      .rsp_value        (rsp.value),
      .rsp_done_res     (rsp.done_res)
   );
endmodule

### rtl/core/eva_ctrl.sv
module eva_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   input  eva_pkg::status_type status,
   output eva_pkg::cmd_type    cmd
);
   import eva_pkg::*;

   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_DIV  = 6'b000010,
      ST_PROG = 6'b000100,
      ST_MUL  = 6'b001000,
      ST_FIN  = 6'b010000,
      ST_OUT  = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load      = 1'b1;
               cmd.div_start = 1'b1;
               state_in      = ST_DIV;
            end
         end
         ST_DIV: begin
            if (status.retarget) begin
               state_in = ST_OUT;
            end else if (status.div_done) begin
               state_in = ST_PROG;
            end else begin
               cmd.div_step = 1'b1;
            end
         end
         ST_PROG: begin
            cmd.prog_update = 1'b1;
            state_in        = ST_MUL;
         end
         ST_MUL: begin
            if (status.mul_done) begin
               state_in = ST_FIN;
            end else begin
               cmd.mul_step = 1'b1;
            end
         end
         ST_FIN: begin
            cmd.finish = 1'b1;
            state_in   = ST_OUT;
         end
         ST_OUT: begin
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = (state_ff == ST_OUT);
endmodule

### rtl/core/eva_dp.sv
module eva_dp #(
   parameter int VALUE_BITS    = eva_pkg::VALUE_BITS_DEF,
   parameter int FRACTION_BITS = eva_pkg::FRACTION_BITS_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  eva_pkg::cmd_type                       cmd,
   output eva_pkg::status_type                    status,
   input  logic                                   req_func,
   input  logic [eva_pkg::ELAPSED_BITS-1:0]       req_elapsed,
   input  logic signed [VALUE_BITS-1:0]           req_new_target,
   input  logic [eva_pkg::DURATION_BITS-1:0]      req_new_duration,
   input  logic [eva_pkg::MODE_BITS-1:0]          easing_mode,
   input  logic [eva_pkg::OVERSHOOT_BITS-1:0]     overshoot,
   output logic signed [VALUE_BITS-1:0]           rsp_value,
   output logic                                   rsp_done_res
);
   import eva_pkg::*;

   localparam int F   = FRACTION_BITS;
   localparam int PB  = F + 1;
   localparam int NB  = ELAPSED_BITS + F;
   localparam int DCW = $clog2(NB + 1);
   localparam int MB0 = (F + 6 > VALUE_BITS + 1) ? F + 6 : VALUE_BITS + 1;
   localparam int MB  = (MB0 > OVERSHOOT_BITS + 2) ? MB0 : OVERSHOOT_BITS + 2;
   localparam int W   = 2 * MB + 2;
   localparam logic [PB-1:0] ONE_P  = PB'(1) << F;
   localparam logic [PB-1:0] HALF_P = PB'(1) << (F - 1);
   localparam logic signed [W-1:0] ONE_W = W'(1) << F;
   localparam logic signed [W-1:0] OVS_ONE_W = W'(1) << OVERSHOOT_FRAC;

   logic signed [VALUE_BITS-1:0] cur_ff, start_ff, target_ff;
   logic [DURATION_BITS-1:0]     len_ff;
   logic [PB-1:0]                prog_ff;
   logic                         retarget_ff;

   logic [NB-1:0]                quo_ff;
   logic [DURATION_BITS:0]       rem_ff;
   logic [DCW-1:0]               dcnt_ff;
   logic [DURATION_BITS:0]       rem_sh;
   logic [NB-1:0]                quo_sh;

   logic signed [W-1:0] acc_ff, acc_in;
   logic signed [W-1:0] t_ff, lin_ff, t2_ff, f_ff, s_ff, e_ff;
   logic [2:0]          mstep_ff;
   logic signed [W-1:0] m_w, u_w, tu_w, mid_w, e_half_w;
   logic                first_in;
   logic                use_in;
   logic                is_linear;
   logic [NB:0]         prog_sum;
   logic [PB-1:0]       prog_new;
   logic signed [VALUE_BITS-1:0] curve_val;
   logic signed [W-1:0] vmax_w, vmin_w;
   logic signed [MB-1:0]   mul_a, mul_b;
   logic signed [2*MB-1:0] mul_p;
   logic signed [W-1:0]    prod_w;

   assign rem_sh = {rem_ff[DURATION_BITS-1:0], quo_ff[NB-1]};
   assign quo_sh = {quo_ff[NB-2:0], 1'b0};

   assign status.div_done = (dcnt_ff == DCW'(NB)) || (len_ff == '0);
   assign status.retarget = retarget_ff;
   assign status.mul_done = (mstep_ff == 3'd5);

   assign prog_sum = (len_ff == '0) ? (NB+1)'(ONE_P)
                                    : ((NB+1)'(prog_ff) + {1'b0, quo_ff});
   assign prog_new = (prog_sum > (NB+1)'(ONE_P)) ? ONE_P : prog_sum[PB-1:0];

   assign m_w   = W'(overshoot);
   assign e_half_w = W'(target_ff) - W'(start_ff);
   assign mid_w = W'(start_ff) + (e_half_w >>> 1);
   assign first_in = (prog_ff < HALF_P);
   assign u_w   = t_ff - ONE_W;
   assign tu_w  = use_in ? t_ff : u_w;
   assign is_linear = (easing_mode == MODE_LINEAR);
   assign vmax_w = W'((64'sd1 <<< (VALUE_BITS - 1)) - 1);
   assign vmin_w = -W'(64'sd1 <<< (VALUE_BITS - 1));

   always_comb begin
      use_in = 1'b1;
      unique case (easing_mode)
         MODE_OUT:    use_in = 1'b0;
         MODE_IN_OUT: use_in = first_in;
         MODE_OUT_IN: use_in = !first_in;
         default:     use_in = 1'b1;
      endcase
   end

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (mstep_ff)
         3'd0: begin
            mul_a = MB'(tu_w);
            mul_b = MB'(tu_w);
         end
         3'd1: begin
            mul_a = MB'(m_w + OVS_ONE_W);
            mul_b = MB'(tu_w);
         end
         3'd2: begin
            mul_a = MB'(t2_ff);
            mul_b = MB'(lin_ff);
         end
         3'd3: begin
            mul_a = MB'(f_ff);
            mul_b = MB'(e_ff - s_ff);
         end
         default: ;
      endcase
   end

   assign mul_p  = mul_a * mul_b;
   assign prod_w = W'(mul_p);

   always_comb begin
      acc_in = acc_ff;
      unique case (mstep_ff)
         3'd0: acc_in = prod_w >>> F;
         3'd1: acc_in = use_in ? (prod_w - (m_w <<< F)) >>> OVERSHOOT_FRAC
                               : (prod_w + (m_w <<< F)) >>> OVERSHOOT_FRAC;
         3'd2: acc_in = is_linear ? t_ff
                      : (use_in ? (prod_w >>> F) : ((prod_w >>> F) + ONE_W));
         3'd3: acc_in = prod_w >>> F;
         3'd4: acc_in = s_ff + acc_ff;
         default: acc_in = acc_ff;
      endcase
   end

   always_comb begin
      if (acc_ff > vmax_w) begin
         curve_val = VALUE_BITS'(vmax_w);
      end else if (acc_ff < vmin_w) begin
         curve_val = VALUE_BITS'(vmin_w);
      end else begin
         curve_val = VALUE_BITS'(acc_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_ff      <= '0;
         start_ff    <= '0;
         target_ff   <= '0;
         len_ff      <= '0;
         prog_ff     <= '0;
         retarget_ff <= 1'b0;
         dcnt_ff     <= '0;
         mstep_ff    <= '0;
      end else begin
         if (cmd.load) begin
            retarget_ff <= (req_func == FUNC_RETARGET);
            if (req_func == FUNC_RETARGET) begin
               start_ff  <= cur_ff;
               target_ff <= req_new_target;
               len_ff    <= req_new_duration;
               prog_ff   <= '0;
            end
            quo_ff  <= NB'(req_elapsed) << F;
            rem_ff  <= '0;
            dcnt_ff <= '0;
         end
         if (cmd.div_step) begin
            if (rem_sh >= {1'b0, len_ff}) begin
               rem_ff <= rem_sh - {1'b0, len_ff};
               quo_ff <= quo_sh | NB'(1);
            end else begin
               rem_ff <= rem_sh;
               quo_ff <= quo_sh;
            end
            dcnt_ff <= dcnt_ff + DCW'(1);
         end
         if (cmd.prog_update) begin
            prog_ff  <= prog_new;
            mstep_ff <= '0;
         end
         if (cmd.mul_step) begin
            unique case (mstep_ff)
               3'd0: t2_ff <= acc_in;
               3'd1: lin_ff <= acc_in;
               3'd2: f_ff <= acc_in;
               default: ;
            endcase
            acc_ff   <= acc_in;
            mstep_ff <= mstep_ff + 3'd1;
         end
         if (cmd.finish) begin
            if (prog_ff == ONE_P) begin
               cur_ff <= target_ff;
            end else if (easing_mode <= MODE_OUT_IN) begin
               cur_ff <= curve_val;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.prog_update) begin
         unique case (easing_mode)
            MODE_IN_OUT, MODE_OUT_IN: begin
               t_ff <= (prog_new < HALF_P) ? (W'(prog_new) <<< 1)
                                           : ((W'(prog_new) <<< 1) - ONE_W);
               s_ff <= (prog_new < HALF_P) ? W'(start_ff) : mid_w;
               e_ff <= (prog_new < HALF_P) ? mid_w : W'(target_ff);
            end
            default: begin
               t_ff <= W'(prog_new);
               s_ff <= W'(start_ff);
               e_ff <= W'(target_ff);
            end
         endcase
      end
   end

   assign rsp_value    = cur_ff;
   assign rsp_done_res = (prog_ff == ONE_P) && (cur_ff == target_ff);
endmodule
